[design/image_header_size_sniffer_macros.svh]
// ----------------------------------------------------------------------------
// image header size sniffer assertion macros
// shared property forms for the sniffer's internal checks
// ----------------------------------------------------------------------------
`ifndef IMAGE_HEADER_SIZE_SNIFFER_MACROS_SVH
`define IMAGE_HEADER_SIZE_SNIFFER_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define IHSS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define IHSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/ihss_pkg.sv]
// ----------------------------------------------------------------------------
// ihss_pkg
// types, codes and constants shared by the image header size sniffer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ihss_pkg;

  // parser phase
  typedef enum logic [3:0] {
    PH_START  = 4'd0,
    PH_SOI2   = 4'd1,
    PH_PNG    = 4'd2,
    PH_MARK   = 4'd3,
    PH_FILL   = 4'd4,
    PH_LEN_HI = 4'd5,
    PH_LEN_LO = 4'd6,
    PH_SKIP   = 4'd7,
    PH_SOF    = 4'd8,
    PH_IGNORE = 4'd9
  } phase_t;

  // outcome of one byte
  typedef enum logic [1:0] {
    OC_PENDING = 2'd0,
    OC_OK      = 2'd1,
    OC_FAIL    = 2'd2
  } outcome_t;

  // image format codes
  localparam logic [1:0] FMT_UNKNOWN = 2'd0;
  localparam logic [1:0] FMT_PNG     = 2'd1;
  localparam logic [1:0] FMT_JPEG    = 2'd2;

  localparam int unsigned DIM_W = 31;
  localparam int unsigned ACC_W = 32;
  localparam int unsigned OFF_W = 5;

  // byte codes
  localparam logic [7:0] PNG_LEAD   = 8'h89;
  localparam logic [7:0] JPEG_SOI   = 8'hD8;
  localparam logic [7:0] JPEG_FILL  = 8'hFF;
  localparam logic [7:0] JPEG_EOI   = 8'hD9;
  localparam logic [7:0] JPEG_TEM   = 8'h01;
  localparam logic [7:0] JPEG_RST0  = 8'hD0;
  localparam logic [7:0] JPEG_DHT   = 8'hC4;
  localparam logic [7:0] JPEG_JPG   = 8'hC8;
  localparam logic [7:0] JPEG_DAC   = 8'hCC;
  localparam logic [7:0] JPEG_SOF0  = 8'hC0;
  localparam logic [7:0] JPEG_SOF15 = 8'hCF;

  // minimum segment lengths
  localparam logic [15:0] SEG_LEN_MIN = 16'd2;
  localparam logic [15:0] SOF_LEN_MIN = 16'd7;

  // png header offsets
  localparam logic [OFF_W-1:0] PNG_TAG_START    = 5'd12;
  localparam logic [OFF_W-1:0] PNG_SIG_END      = 5'd8;
  localparam logic [OFF_W-1:0] PNG_TAG_END      = 5'd16;
  localparam logic [OFF_W-1:0] PNG_HEIGHT_START = 5'd20;
  localparam logic [OFF_W-1:0] PNG_LAST_OFF     = 5'd23;

  // sof field offsets
  localparam logic [OFF_W-1:0] SOF_PREC_OFF   = 5'd0;
  localparam logic [OFF_W-1:0] SOF_WIDTH_OFF  = 5'd3;
  localparam logic [OFF_W-1:0] SOF_LAST_OFF   = 5'd4;

  // one result transfer
  typedef struct packed {
    logic             found;
    logic [1:0]       image_format;
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
  } result_t;

  // png signature byte by offset
  function automatic logic [7:0] png_sig_byte(input logic [2:0] idx);
    logic [7:0] val;
    case (idx)
      3'd0:    val = 8'h89;
      3'd1:    val = 8'h50;
      3'd2:    val = 8'h4E;
      3'd3:    val = 8'h47;
      3'd4:    val = 8'h0D;
      3'd5:    val = 8'h0A;
      3'd6:    val = 8'h1A;
      default: val = 8'h0A;
    endcase
    return val;
  endfunction

  // ihdr tag byte by offset
  function automatic logic [7:0] png_tag_byte(input logic [1:0] idx);
    logic [7:0] val;
    case (idx)
      2'd0:    val = 8'h49;
      2'd1:    val = 8'h48;
      2'd2:    val = 8'h44;
      default: val = 8'h52;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

[design/ihss_parse.sv]
// ----------------------------------------------------------------------------
// ihss_parse
// byte-wise header parser: phase register, counters and accumulators, with
// the outcome of each accepted byte worked out in one pass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "image_header_size_sniffer_macros.svh"

module ihss_parse (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire logic [7:0]       data_byte,
  input  wire logic             last_byte,
  output logic                  res_valid,
  output ihss_pkg::result_t     res
);
  import ihss_pkg::*;

  phase_t                phase, phase_next;
  logic [OFF_W-1:0]      offset, offset_next, off_inc;
  logic [15:0]           remaining, remaining_next;
  logic [7:0]            marker, marker_next;
  logic [7:0]            len_hi, len_hi_next;
  logic [ACC_W-1:0]      width, width_next;
  logic [ACC_W-1:0]      height, height_next;
  logic [1:0]            fmt, fmt_step, fmt_next;
  outcome_t              outcome;
  logic [15:0]           seg_len;
  logic                  is_sof, is_standalone, decided;

  assign off_inc = offset + 5'd1;
  assign seg_len = {len_hi, data_byte};
  assign is_sof  = (marker >= JPEG_SOF0) && (marker <= JPEG_SOF15) &&
                   (marker != JPEG_DHT) && (marker != JPEG_JPG) &&
                   (marker != JPEG_DAC);
  assign is_standalone = (data_byte == JPEG_TEM) ||
                         ((data_byte >= JPEG_RST0) && (data_byte <= JPEG_EOI));

  // next state
  always_comb begin
    phase_next     = phase;
    offset_next    = offset;
    remaining_next = remaining;
    marker_next    = marker;
    len_hi_next    = len_hi;
    width_next     = width;
    height_next    = height;
    fmt_step       = fmt;
    outcome        = OC_PENDING;
    unique case (phase)
      PH_START: begin
        if (data_byte == PNG_LEAD) begin
          fmt_step    = FMT_PNG;
          phase_next  = PH_PNG;
          offset_next = off_inc;
        end else if (data_byte == JPEG_FILL) begin
          phase_next = PH_SOI2;
        end else begin
          outcome = OC_FAIL;
        end
      end
      PH_SOI2: begin
        if (data_byte == JPEG_SOI) begin
          fmt_step   = FMT_JPEG;
          phase_next = PH_MARK;
        end else begin
          outcome = OC_FAIL;
        end
      end
      PH_PNG: begin
        offset_next = off_inc;
        if (offset < PNG_SIG_END) begin
          if (data_byte != png_sig_byte(offset[2:0])) outcome = OC_FAIL;
        end else if (offset < PNG_TAG_START) begin
          outcome = OC_PENDING;
        end else if (offset < PNG_TAG_END) begin
          if (data_byte != png_tag_byte(offset[1:0])) outcome = OC_FAIL;
        end else if (offset < PNG_HEIGHT_START) begin
          width_next = {width[ACC_W-9:0], data_byte};
        end else begin
          height_next = {height[ACC_W-9:0], data_byte};
          if (offset == PNG_LAST_OFF) begin
            if ((width == '0) || (height_next == '0) ||
                width[ACC_W-1] || height_next[ACC_W-1]) begin
              outcome = OC_FAIL;
            end else begin
              outcome = OC_OK;
            end
          end
        end
      end
      PH_MARK: begin
        if (data_byte != JPEG_FILL) outcome = OC_FAIL;
        else phase_next = PH_FILL;
      end
      PH_FILL: begin
        if (data_byte != JPEG_FILL) begin
          marker_next = data_byte;
          if (is_standalone) begin
            if (data_byte == JPEG_EOI) outcome = OC_FAIL;
            else phase_next = PH_MARK;
          end else begin
            phase_next = PH_LEN_HI;
          end
        end
      end
      PH_LEN_HI: begin
        len_hi_next = data_byte;
        phase_next  = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        if (seg_len < SEG_LEN_MIN) begin
          outcome = OC_FAIL;
        end else if (is_sof) begin
          if (seg_len < SOF_LEN_MIN) begin
            outcome = OC_FAIL;
          end else begin
            offset_next = '0;
            width_next  = '0;
            height_next = '0;
            phase_next  = PH_SOF;
          end
        end else begin
          remaining_next = seg_len - SEG_LEN_MIN;
          phase_next     = (seg_len == SEG_LEN_MIN) ? PH_MARK : PH_SKIP;
        end
      end
      PH_SKIP: begin
        remaining_next = remaining - 16'd1;
        if (remaining == 16'd1) phase_next = PH_MARK;
      end
      PH_SOF: begin
        offset_next = off_inc;
        if (offset == SOF_PREC_OFF) begin
          outcome = OC_PENDING;
        end else if (offset < SOF_WIDTH_OFF) begin
          height_next = {16'd0, height[7:0], data_byte};
        end else begin
          width_next = {16'd0, width[7:0], data_byte};
          if (offset == SOF_LAST_OFF) begin
            if ((width_next == '0) || (height == '0)) outcome = OC_FAIL;
            else outcome = OC_OK;
          end
        end
      end
      PH_IGNORE: begin
        outcome = OC_PENDING;
      end
      default: begin
        outcome = OC_FAIL;
      end
    endcase

    // a file cut short fails on its last byte
    if ((phase != PH_IGNORE) && (outcome == OC_PENDING) && last_byte) begin
      outcome = OC_FAIL;
    end
    decided = (phase != PH_IGNORE) && (outcome != OC_PENDING);
    fmt_next = fmt_step;
    if (decided) phase_next = PH_IGNORE;

    // last byte returns to start of file
    if (last_byte) begin
      phase_next  = PH_START;
      offset_next = '0;
      fmt_next    = FMT_UNKNOWN;
    end
  end

  // result of the deciding byte
  always_comb begin
    res_valid        = accept && decided;
    res.found        = (outcome == OC_OK);
    res.image_format = fmt_step;
    res.image_width  = (outcome == OC_OK) ? width_next[DIM_W-1:0] : '0;
    res.image_height = (outcome == OC_OK) ? height_next[DIM_W-1:0] : '0;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_START;
      offset <= '0;
      fmt    <= FMT_UNKNOWN;
    end else if (accept) begin
      phase  <= phase_next;
      offset <= offset_next;
      fmt    <= fmt_next;
    end
  end

  // segment and size accumulators
  always_ff @(posedge clk) begin
    if (accept) begin
      remaining <= remaining_next;
      marker    <= marker_next;
      len_hi    <= len_hi_next;
      width     <= width_next;
      height    <= height_next;
    end
  end

  `IHSS_ASSERT_NEXT(a_last_restarts, clk, rst, accept && last_byte,
    (phase == PH_START) && (offset == '0) && (fmt == FMT_UNKNOWN),
    "last byte did not return parser to start of file")
  `IHSS_ASSERT_NEXT(a_decided_ignores, clk, rst, res_valid && !last_byte,
    phase == PH_IGNORE, "decided file not ignoring further bytes")
  `IHSS_ASSERT_SAME(a_png_format, clk, rst, phase == PH_PNG,
    fmt == FMT_PNG, "png phase without png format")

endmodule

`default_nettype wire

[design/ihss_skid.sv]
// ----------------------------------------------------------------------------
// ihss_skid
// result output register with one skid entry, so input ready is registered
// and bytes keep flowing while a result waits
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "image_header_size_sniffer_macros.svh"

module ihss_skid (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load_valid,
  input  wire ihss_pkg::result_t load_data,
  output logic                   load_ready,
  output logic                   out_valid,
  output ihss_pkg::result_t      out_data,
  input  wire logic              out_ready
);
  import ihss_pkg::*;

  logic    skid_valid;
  result_t skid_data;
  logic    out_free;

  assign out_free   = !out_valid || out_ready;
  assign load_ready = !skid_valid;

  // output and skid valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid && out_free) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else if (load_valid) begin
      if (out_free) out_valid <= 1'b1;
      else skid_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (skid_valid && out_free) begin
      out_data <= skid_data;
    end else if (load_valid) begin
      if (out_free) out_data <= load_data;
      else skid_data <= load_data;
    end
  end

  `IHSS_ASSERT_SAME(a_skid_behind_out, clk, rst, skid_valid, out_valid,
    "skid entry held while output register empty")
  `IHSS_ASSERT_SAME(a_no_load_when_full, clk, rst, load_valid, !skid_valid,
    "result offered while skid entry full")
  `IHSS_ASSERT_NEXT(a_skid_holds, clk, rst, skid_valid && !out_ready,
    skid_valid && $stable(skid_data), "skid entry lost while output stalled")

endmodule

`default_nettype wire

[design/image_header_size_sniffer.sv]
// ----------------------------------------------------------------------------
// image_header_size_sniffer
// reads the pixel size from the header of a png or jpeg file streamed in
// one byte per transfer
// ----------------------------------------------------------------------------
// usage
//   slave side: one file byte per transfer on s_tdata, s_tlast on the file's
//   final byte. master side: one result per file, on m_tuser the found flag
//   and format code, on m_tdata the width and height (zero unless found).
//   a result transfer is registered onto m_tvalid once the byte that decides
//   the outcome is taken. while s_tready is high, throughput is one byte per
//   cycle; each byte is a single pass through the parser's phase register and
//   accumulators, so the phase update bounds it.
//   bytes after the deciding one are dropped up to and including the last
//   byte; the next byte starts a new file.
//   reset returns the parser to start of file and empties the output stage.
//   when the receiver stalls, the result sits in the output register and
//   bytes keep being taken; a second result parks in a skid entry, and
//   s_tready drops only while that entry is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module image_header_size_sniffer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // data_byte
  input  wire logic        s_tlast,   // last_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,   // image_width [30:0], image_height [61:31]
  output logic [2:0]       m_tuser    // found [0], image_format [2:1]
);
  import ihss_pkg::*;

  logic    accept;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign accept = s_tvalid && s_tready;

  // byte parser
  ihss_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (s_tdata),
    .last_byte (s_tlast),
    .res_valid (res_valid),
    .res       (res)
  );

  // result output stage
  ihss_skid u_skid (
    .clk        (clk),
    .rst        (rst),
    .load_valid (res_valid),
    .load_data  (res),
    .load_ready (s_tready),
    .out_valid  (m_tvalid),
    .out_data   (out_res),
    .out_ready  (m_tready)
  );

  // pack the result transfer
  assign m_tdata = {2'b00, out_res.image_height, out_res.image_width};
  assign m_tuser = {out_res.image_format, out_res.found};

endmodule

`default_nettype wire

[verif/image_header_size_sniffer_test.sv]
// ----------------------------------------------------------------------------
// image_header_size_sniffer_test
// streams png, jpeg and junk files through the sniffer byte by byte, predicts
// the size report for every file and compares each result transfer with it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module image_header_size_sniffer_test;
  import ihss_pkg::*;

  localparam int          STALL_LIMIT = 5000;
  localparam int          ITEM_TARGET = 1850;
  localparam int          TAIL_CYCLES = 8;
  localparam logic [63:0] PNG_MAGIC   = 64'h89504E470D0A1A0A;
  localparam logic [31:0] IHDR_TAG    = 32'h49484452;
  localparam logic [31:0] IHDR_LEN    = 32'd13;
  localparam logic [7:0]  JPEG_APP0   = 8'hE0;
  localparam logic [7:0]  JPEG_SOF1   = 8'hC1;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic [2:0]  m_tuser;

  image_header_size_sniffer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // data_byte
    .s_tlast  (s_tlast),   // last_byte
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // image_width [30:0], image_height [61:31]
    .m_tuser  (m_tuser)    // found [0], image_format [2:1]
  );

  // predicted parser state
  phase_t      sn_phase;
  logic [4:0]  sn_off;
  logic [15:0] sn_seg_left;
  logic [7:0]  sn_marker;
  logic [15:0] sn_seg_len;
  logic [31:0] sn_wacc;
  logic [31:0] sn_hacc;
  logic [1:0]  sn_fmt;
  logic        sn_done;

  result_t     expected_sizes[$];
  logic [7:0]  file_q[$];
  int          fail_count = 0;
  int          sent_bytes = 0;
  int          tx_gap_pct = 33;
  int          rx_idle_pct = 25;
  int          stall_cycles = 0;

  // clock
  initial begin
    forever #6 clk = ~clk;
  end

  // receiver stalls at random
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // size prediction
  // ---------------------------------------------------------------------------

  function automatic void sniff_clear();
    sn_phase    = PH_START;
    sn_off      = '0;
    sn_seg_left = '0;
    sn_marker   = '0;
    sn_seg_len  = '0;
    sn_wacc     = '0;
    sn_hacc     = '0;
    sn_fmt      = FMT_UNKNOWN;
    sn_done     = 1'b0;
  endfunction

  function automatic bit is_sof(input logic [7:0] code);
    return code >= JPEG_SOF0 && code <= JPEG_SOF15 &&
           code != JPEG_DHT && code != JPEG_JPG && code != JPEG_DAC;
  endfunction

  function automatic bit is_standalone(input logic [7:0] code);
    return code == JPEG_TEM || (code >= JPEG_RST0 && code <= JPEG_EOI);
  endfunction

  // one byte of the png header
  function automatic outcome_t png_step(input logic [7:0] b);
    logic [4:0] o;
    o = sn_off;
    sn_off = sn_off + 5'd1;
    if (o < PNG_SIG_END)
      return (b == PNG_MAGIC[8*(7-o) +: 8]) ? OC_PENDING : OC_FAIL;
    if (o < PNG_TAG_START)
      return OC_PENDING;
    if (o < PNG_TAG_END)
      return (b == IHDR_TAG[8*(15-o) +: 8]) ? OC_PENDING : OC_FAIL;
    if (o < PNG_HEIGHT_START) begin
      sn_wacc = {sn_wacc[23:0], b};
      return OC_PENDING;
    end
    sn_hacc = {sn_hacc[23:0], b};
    if (o < PNG_LAST_OFF)
      return OC_PENDING;
    if (sn_wacc == '0 || sn_hacc == '0 || sn_wacc[31] || sn_hacc[31])
      return OC_FAIL;
    return OC_OK;
  endfunction

  // advance the prediction by one accepted byte; 1 when it yields a result
  function automatic bit sniff_byte(input logic [7:0] b, input logic last,
                                    output result_t res);
    outcome_t   oc;
    logic [4:0] o;
    res = '0;
    if (sn_phase == PH_IGNORE || sn_done) begin
      if (last)
        sniff_clear();
      return 1'b0;
    end
    oc = OC_PENDING;
    case (sn_phase)
      PH_START: begin
        if (b == PNG_LEAD) begin
          sn_fmt   = FMT_PNG;
          sn_phase = PH_PNG;
          oc       = png_step(b);
        end else if (b == JPEG_FILL) begin
          sn_phase = PH_SOI2;
        end else begin
          oc = OC_FAIL;
        end
      end
      PH_SOI2: begin
        if (b == JPEG_SOI) begin
          sn_fmt   = FMT_JPEG;
          sn_phase = PH_MARK;
        end else begin
          oc = OC_FAIL;
        end
      end
      PH_PNG: oc = png_step(b);
      PH_MARK: begin
        if (b != JPEG_FILL)
          oc = OC_FAIL;
        else
          sn_phase = PH_FILL;
      end
      // fill bytes repeat until the marker code
      PH_FILL: begin
        if (b != JPEG_FILL) begin
          sn_marker = b;
          if (is_standalone(b)) begin
            if (b == JPEG_EOI)
              oc = OC_FAIL;
            else
              sn_phase = PH_MARK;
          end else begin
            sn_phase = PH_LEN_HI;
          end
        end
      end
      PH_LEN_HI: begin
        sn_seg_len = {b, 8'h00};
        sn_phase   = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        sn_seg_len = {sn_seg_len[15:8], b};
        if (sn_seg_len < SEG_LEN_MIN) begin
          oc = OC_FAIL;
        end else if (is_sof(sn_marker)) begin
          if (sn_seg_len < SOF_LEN_MIN) begin
            oc = OC_FAIL;
          end else begin
            sn_off   = '0;
            sn_wacc  = '0;
            sn_hacc  = '0;
            sn_phase = PH_SOF;
          end
        end else begin
          sn_seg_left = sn_seg_len - SEG_LEN_MIN;
          sn_phase    = (sn_seg_left == '0) ? PH_MARK : PH_SKIP;
        end
      end
      PH_SKIP: begin
        sn_seg_left = sn_seg_left - 16'd1;
        if (sn_seg_left == '0)
          sn_phase = PH_MARK;
      end
      // precision, then 16-bit height and width
      PH_SOF: begin
        o = sn_off;
        sn_off = sn_off + 5'd1;
        if (o == SOF_PREC_OFF) begin
          oc = OC_PENDING;
        end else if (o < SOF_WIDTH_OFF) begin
          sn_hacc = {16'h0000, sn_hacc[7:0], b};
        end else begin
          sn_wacc = {16'h0000, sn_wacc[7:0], b};
          if (o >= SOF_LAST_OFF)
            oc = (sn_wacc == '0 || sn_hacc == '0) ? OC_FAIL : OC_OK;
        end
      end
      default: oc = OC_FAIL;
    endcase
    // a file that ends undecided fails on its last byte
    if (oc == OC_PENDING && last)
      oc = OC_FAIL;
    if (oc == OC_PENDING)
      return 1'b0;
    res.found        = (oc == OC_OK);
    res.image_format = sn_fmt;
    res.image_width  = (oc == OC_OK) ? sn_wacc[DIM_W-1:0] : '0;
    res.image_height = (oc == OC_OK) ? sn_hacc[DIM_W-1:0] : '0;
    if (last) begin
      sniff_clear();
    end else begin
      sn_phase = PH_IGNORE;
      sn_done  = 1'b1;
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // prediction on each byte transfer, comparison on each result transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : size_check
    result_t want;
    result_t got;
    if (rst) begin
      sniff_clear();
    end else begin
      if (s_tvalid && s_tready) begin
        if (sniff_byte(s_tdata, s_tlast, want))
          expected_sizes.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        got.found        = m_tuser[0];
        got.image_format = m_tuser[2:1];
        got.image_width  = m_tdata[30:0];
        got.image_height = m_tdata[61:31];
        if (expected_sizes.size() == 0) begin
          $display("%0t: result with nothing expected: found %0d format %0d size %0dx%0d",
                   $time, got.found, got.image_format, got.image_width,
                   got.image_height);
          fail_count++;
        end else begin
          want = expected_sizes.pop_front();
          if (got.found !== want.found) begin
            $display("%0t: found expected %0d actual %0d", $time, want.found,
                     got.found);
            fail_count++;
          end
          if (got.image_format !== want.image_format) begin
            $display("%0t: image_format expected %0d actual %0d", $time,
                     want.image_format, got.image_format);
            fail_count++;
          end
          if (got.image_width !== want.image_width) begin
            $display("%0t: image_width expected %0d actual %0d", $time,
                     want.image_width, got.image_width);
            fail_count++;
          end
          if (got.image_height !== want.image_height) begin
            $display("%0t: image_height expected %0d actual %0d", $time,
                     want.image_height, got.image_height);
            fail_count++;
          end
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sending
  // ---------------------------------------------------------------------------

  // one byte transfer, with a random gap in front of it
  task automatic send_byte(input logic [7:0] b, input logic last);
    if ($urandom_range(0, 99) < tx_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready)
      @(posedge clk);
    sent_bytes++;
  endtask

  // send the assembled file, last flag on its final byte
  task automatic send_file();
    int i;
    for (i = 0; i < file_q.size(); i++)
      send_byte(file_q[i], i == file_q.size() - 1);
    file_q.delete();
  endtask

  // hold the sender until every predicted result has arrived
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    do
      @(posedge clk);
    while (expected_sizes.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // file assembly
  // ---------------------------------------------------------------------------

  task automatic add_png(input logic [31:0] w, input logic [31:0] h);
    int i;
    for (i = 0; i < 8; i++)
      file_q.push_back(PNG_MAGIC[8*(7-i) +: 8]);
    for (i = 0; i < 4; i++)
      file_q.push_back(IHDR_LEN[8*(3-i) +: 8]);
    for (i = 0; i < 4; i++)
      file_q.push_back(IHDR_TAG[8*(3-i) +: 8]);
    for (i = 0; i < 4; i++)
      file_q.push_back(w[8*(3-i) +: 8]);
    for (i = 0; i < 4; i++)
      file_q.push_back(h[8*(3-i) +: 8]);
  endtask

  // marker segment with random payload
  task automatic add_segment(input logic [7:0] code, input logic [15:0] len);
    file_q.push_back(JPEG_FILL);
    file_q.push_back(code);
    file_q.push_back(len[15:8]);
    file_q.push_back(len[7:0]);
    repeat (int'(len) - 2)
      file_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic add_sof(input logic [7:0] code, input logic [15:0] len,
                         input logic [15:0] h, input logic [15:0] w);
    file_q.push_back(JPEG_FILL);
    file_q.push_back(code);
    file_q.push_back(len[15:8]);
    file_q.push_back(len[7:0]);
    file_q.push_back(8'($urandom_range(0, 255)));
    file_q.push_back(h[15:8]);
    file_q.push_back(h[7:0]);
    file_q.push_back(w[15:8]);
    file_q.push_back(w[7:0]);
  endtask

  task automatic add_soi();
    file_q.push_back(JPEG_FILL);
    file_q.push_back(JPEG_SOI);
  endtask

  // png dimension with its limits favoured
  function automatic logic [31:0] pick_dim32();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)  return 32'd0;
    if (r < 16) return 32'h7FFFFFFF;
    if (r < 24) return {1'b1, 31'($urandom)};
    if (r < 32) return 32'd1;
    return {1'b0, 31'($urandom)};
  endfunction

  function automatic logic [15:0] pick_dim16();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'd0;
    if (r < 20) return 16'hFFFF;
    if (r < 30) return 16'd1;
    return 16'($urandom);
  endfunction

  // mostly well-formed headers with random content, some damaged or junk
  task automatic random_file();
    int         kind;
    int         n;
    logic [7:0] code;
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      add_png(pick_dim32(), pick_dim32());
    end else if (kind < 85) begin
      add_soi();
      repeat ($urandom_range(0, 3)) begin
        repeat ($urandom_range(0, 2))
          file_q.push_back(JPEG_FILL);
        if ($urandom_range(0, 2) == 0) begin
          n = $urandom_range(0, 9);
          code = (n == 9) ? JPEG_TEM : JPEG_RST0 + 8'(n);
          file_q.push_back(JPEG_FILL);
          file_q.push_back(code);
        end else begin
          do
            code = 8'($urandom_range(0, 254));
          while (is_sof(code) || is_standalone(code));
          add_segment(code, 16'($urandom_range(2, 6)));
        end
      end
      do
        code = 8'($urandom_range(JPEG_SOF0, JPEG_SOF15));
      while (!is_sof(code));
      add_sof(code, 16'($urandom_range(7, 17)), pick_dim16(), pick_dim16());
    end else begin
      repeat ($urandom_range(1, 6))
        file_q.push_back(8'($urandom_range(0, 255)));
    end
    // damage one byte now and then
    if ($urandom_range(0, 99) < 12)
      file_q[$urandom_range(0, file_q.size() - 1)] = 8'($urandom_range(0, 255));
    // cut short, or pad with bytes the sniffer must drop
    if ($urandom_range(0, 99) < 10) begin
      n = $urandom_range(1, file_q.size());
      while (file_q.size() > n)
        void'(file_q.pop_back());
    end else begin
      repeat ($urandom_range(0, 3))
        file_q.push_back(8'($urandom_range(0, 255)));
    end
    send_file();
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  task automatic test_png_headers();
    add_png(32'd1, 32'h7FFFFFFF);
    send_file();
    add_png(32'h7FFFFFFF, 32'd1);
    file_q.push_back(8'h00);
    file_q.push_back(8'hFF);
    send_file();
    // zero and oversized dimensions
    add_png(32'd0, 32'd5);
    send_file();
    add_png(32'd7, 32'h80000000);
    send_file();
    add_png(32'hFFFFFFFF, 32'hFFFFFFFF);
    send_file();
    // broken signature, broken tag
    add_png(32'd3, 32'd3);
    file_q[3] = 8'h00;
    send_file();
    add_png(32'd3, 32'd3);
    file_q[14] = 8'hFF;
    send_file();
    // cut inside the height
    add_png(32'd9, 32'd9);
    while (file_q.size() > 21)
      void'(file_q.pop_back());
    send_file();
    wait_for_results();
  endtask

  task automatic test_jpeg_markers();
    add_soi();
    add_sof(JPEG_SOF0, SOF_LEN_MIN, 16'd1, 16'd1);
    send_file();
    // fill bytes before the marker, largest size
    add_soi();
    file_q.push_back(JPEG_FILL);
    file_q.push_back(JPEG_FILL);
    add_sof(JPEG_SOF15, 16'd17, 16'hFFFF, 16'hFFFF);
    send_file();
    // standalone markers and skipped segments ahead of the frame header
    add_soi();
    file_q.push_back(JPEG_FILL);
    file_q.push_back(JPEG_TEM);
    file_q.push_back(JPEG_FILL);
    file_q.push_back(JPEG_RST0);
    add_segment(JPEG_APP0, SEG_LEN_MIN);
    add_segment(JPEG_DHT, 16'd5);
    add_segment(JPEG_JPG, 16'd3);
    add_segment(JPEG_DAC, 16'd4);
    add_segment(JPEG_APP0, 16'h0102);
    add_sof(JPEG_SOF1, 16'd17, 16'd480, 16'd640);
    file_q.push_back(8'h55);
    send_file();
    // end of image before any frame header
    add_soi();
    file_q.push_back(JPEG_FILL);
    file_q.push_back(JPEG_EOI);
    file_q.push_back(8'h00);
    send_file();
    // segment length too small
    add_soi();
    file_q.push_back(JPEG_FILL);
    file_q.push_back(JPEG_APP0);
    file_q.push_back(8'h00);
    file_q.push_back(8'h01);
    file_q.push_back(8'hAA);
    send_file();
    // frame header length too small
    add_soi();
    add_sof(JPEG_SOF0, SOF_LEN_MIN - 16'd1, 16'd4, 16'd4);
    send_file();
    // zero width, zero height
    add_soi();
    add_sof(JPEG_SOF1, SOF_LEN_MIN, 16'd8, 16'd0);
    send_file();
    add_soi();
    add_sof(JPEG_SOF1, SOF_LEN_MIN, 16'd0, 16'd8);
    send_file();
    // marker does not start with a fill byte
    add_soi();
    file_q.push_back(8'h00);
    file_q.push_back(JPEG_FILL);
    send_file();
    // cut inside a skipped segment
    add_soi();
    add_segment(JPEG_APP0, 16'd16);
    while (file_q.size() > 9)
      void'(file_q.pop_back());
    send_file();
    wait_for_results();
  endtask

  task automatic test_short_and_unknown();
    send_byte(PNG_LEAD, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(JPEG_FILL, 1'b1);
    // unknown leading byte, the rest dropped
    file_q.push_back(8'h42);
    file_q.push_back(PNG_LEAD);
    file_q.push_back(JPEG_FILL);
    send_file();
    file_q.push_back(JPEG_FILL);
    file_q.push_back(8'h00);
    send_file();
    add_soi();
    send_file();
    wait_for_results();
  endtask

  // back to back on both sides
  task automatic test_random_steady();
    int stop_at;
    tx_gap_pct  = 0;
    rx_idle_pct = 0;
    stop_at = sent_bytes + 300;
    while (sent_bytes < stop_at)
      random_file();
    wait_for_results();
    tx_gap_pct  = 33;
    rx_idle_pct = 25;
  endtask

  task automatic test_random_files();
    int files;
    files = 0;
    while (sent_bytes < ITEM_TARGET) begin
      random_file();
      files++;
      if (files % 20 == 0)
        wait_for_results();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_png_headers();
    test_jpeg_markers();
    test_short_and_unknown();
    test_random_steady();
    test_random_files();
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire
